[sv/sgbf_pkg.sv]
// Shared constants, types and byte tables of the stored gzip block framer.
package sgbf_pkg;

	localparam int STORE_BYTES = 32768;
	localparam int ADDR_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
	localparam int IDX_W = 17;
	localparam int CNT_W = 16;

	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_CLOSE = 2'd1;
	localparam logic [1:0] KIND_CLOSE_EOF = 2'd2;
	localparam logic [1:0] KIND_PULL = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_REFUSED = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam logic [IDX_W-1:0] HEAD_LEN = IDX_W'(16);
	localparam logic [IDX_W-1:0] PRE_DATA = IDX_W'(23);
	localparam logic [CNT_W-1:0] BSIZE_ADD = CNT_W'(30);
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

	// j counts from the first byte after the data: CRC, ISIZE, then marker
	localparam logic [IDX_W:0] J_MEMBER_END = (IDX_W+1)'(7);
	localparam logic [IDX_W:0] J_MARKER_END = (IDX_W+1)'(35);
	localparam logic [4:0] J_MARKER_BASE = 5'd8;

	typedef struct packed {
		logic [7:0] byte_val;
		logic last;
		logic sel_ram;
		logic done;
	} emit_t;

	function automatic logic [7:0] head_byte(input logic [3:0] idx);
		logic [7:0] b;
		unique case (idx)
			4'd0: b = 8'h1f;
			4'd1: b = 8'h8b;
			4'd2: b = 8'h08;
			4'd3: b = 8'h04;
			4'd9: b = 8'hff;
			4'd10: b = 8'h06;
			4'd12: b = 8'h42;
			4'd13: b = 8'h43;
			4'd14: b = 8'h02;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] marker_byte(input logic [4:0] idx);
		logic [7:0] b;
		if (idx < 5'd16) begin
			b = head_byte(idx[3:0]);
		end else begin
			unique case (idx)
				5'd16: b = 8'h1b;
				5'd18: b = 8'h03;
				default: b = 8'h00;
			endcase
		end
		return b;
	endfunction

	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
		input logic [7:0] b);
		logic [31:0] c;
		c = crc_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

[sv/sgbf_store.sv]
// Block store: one write port, one registered read port.
module sgbf_store (
	input  logic                       clk,
	input  logic                       we,
	input  logic [sgbf_pkg::ADDR_W-1:0] waddr,
	input  logic [7:0]                 wdata,
	input  logic                       re,
	input  logic [sgbf_pkg::ADDR_W-1:0] raddr,
	output logic [7:0]                 rdata
);

	logic [7:0] mem [sgbf_pkg::STORE_BYTES];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/sgbf_emit.sv]
// Member and end marker byte selection for one drain position.
module sgbf_emit (
	input  logic [sgbf_pkg::IDX_W-1:0]  idx,
	input  logic [sgbf_pkg::CNT_W-1:0]  count,
	input  logic [31:0]                 crc,
	input  logic                        marker,
	output sgbf_pkg::emit_t             emit,
	output logic [sgbf_pkg::ADDR_W-1:0] raddr
);

	logic [sgbf_pkg::CNT_W-1:0] bsize;
	logic [sgbf_pkg::CNT_W-1:0] nlen;
	logic [31:0] crc_fin;
	logic [sgbf_pkg::IDX_W-1:0] k;
	logic [sgbf_pkg::IDX_W:0] j;
	logic [4:0] m;

	assign bsize = count + sgbf_pkg::BSIZE_ADD;
	assign nlen = ~count;
	assign crc_fin = ~crc;
	assign k = idx - sgbf_pkg::PRE_DATA;
	assign j = {1'b0, k} - {{(sgbf_pkg::IDX_W+1-sgbf_pkg::CNT_W){1'b0}}, count};
	assign m = j[4:0] - sgbf_pkg::J_MARKER_BASE;
	assign raddr = k[sgbf_pkg::ADDR_W-1:0];

	always_comb begin
		emit = '0;
		if (idx < sgbf_pkg::HEAD_LEN) begin
			emit.byte_val = sgbf_pkg::head_byte(idx[3:0]);
		end else if (idx < sgbf_pkg::PRE_DATA) begin
			unique case (idx[2:0])
				3'd0: emit.byte_val = bsize[7:0];
				3'd1: emit.byte_val = bsize[15:8];
				3'd2: emit.byte_val = 8'h01;
				3'd3: emit.byte_val = count[7:0];
				3'd4: emit.byte_val = count[15:8];
				3'd5: emit.byte_val = nlen[7:0];
				3'd6: emit.byte_val = nlen[15:8];
				default: emit.byte_val = 8'h00;
			endcase
		end else if (j[sgbf_pkg::IDX_W]) begin
			emit.sel_ram = 1'b1;
		end else if (j < (sgbf_pkg::IDX_W+1)'(4)) begin
			emit.byte_val = crc_fin[8*j[1:0] +: 8];
		end else if (j < (sgbf_pkg::IDX_W+1)'(8)) begin
			emit.byte_val = (j[1] == 1'b0) ? count[8*j[0] +: 8] : 8'h00;
		end else begin
			emit.byte_val = sgbf_pkg::marker_byte(m);
		end
		if (idx >= sgbf_pkg::PRE_DATA && !j[sgbf_pkg::IDX_W]) begin
			emit.last = (j == sgbf_pkg::J_MEMBER_END) || (j == sgbf_pkg::J_MARKER_END);
			emit.done = marker ? (j == sgbf_pkg::J_MARKER_END)
			                   : (j == sgbf_pkg::J_MEMBER_END);
		end
	end

endmodule

[sv/stored_gzip_block_framer.sv]
// Top level: stored gzip block framer with CRC-32 over a block store.
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------
//  in      | in_valid, in_ready  | kind, data_byte
//  res     | res_valid, res_ready| out_valid, out_byte, out_last, status
//
// One item per cycle while res does not stall; every item gives one result after acceptance,
// through one stage for the store read and one output register.
// The store takes at most one write (payload byte) or one read (pulled data byte) per item.
// The block store has no reset; count, CRC and drain state reset at once.
// A stall on res holds the output and the stage behind it, and drops in_ready while that stage holds an item.
module stored_gzip_block_framer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] kind,
	input  logic [7:0] data_byte,
	output logic       res_valid,
	input  logic       res_ready,
	output logic       out_valid,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic [1:0] status
);

	logic [sgbf_pkg::CNT_W-1:0] fill_q;
	logic [31:0] crc_q;
	logic drain_q;
	logic [sgbf_pkg::IDX_W-1:0] idx_q;
	logic marker_q;

	logic v_s1, oval_s1, last_s1, ram_s1;
	logic [7:0] byte_s1;
	logic [1:0] status_s1;

	logic res_v_q, oval_q, olast_q;
	logic [7:0] obyte_q;
	logic [1:0] status_q;

	logic acc, adv, full, take_byte, take_close, do_pull;
	logic [7:0] rdata;
	logic [sgbf_pkg::ADDR_W-1:0] raddr;
	sgbf_pkg::emit_t emit;

	assign adv = !res_v_q || res_ready;
	assign in_ready = !v_s1 || adv;
	assign acc = in_valid && in_ready;
	assign full = fill_q >= sgbf_pkg::CNT_W'(sgbf_pkg::STORE_BYTES);
	assign take_byte = acc && kind == sgbf_pkg::KIND_BYTE && !drain_q && !full;
	assign take_close = acc && (kind == sgbf_pkg::KIND_CLOSE || kind == sgbf_pkg::KIND_CLOSE_EOF)
	                    && !drain_q;
	assign do_pull = acc && kind == sgbf_pkg::KIND_PULL && drain_q;

	sgbf_emit u_emit (
		.idx(idx_q),
		.count(fill_q),
		.crc(crc_q),
		.marker(marker_q),
		.emit(emit),
		.raddr(raddr)
	);

	sgbf_store u_store (
		.clk(clk),
		.we(take_byte),
		.waddr(fill_q[sgbf_pkg::ADDR_W-1:0]),
		.wdata(data_byte),
		.re(do_pull && emit.sel_ram),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			crc_q <= sgbf_pkg::CRC_INIT;
			drain_q <= 1'b0;
			idx_q <= '0;
			marker_q <= 1'b0;
		end else begin
			if (take_byte) begin
				fill_q <= fill_q + sgbf_pkg::CNT_W'(1);
				crc_q <= sgbf_pkg::crc_byte(crc_q, data_byte);
			end
			if (take_close) begin
				drain_q <= 1'b1;
				idx_q <= '0;
				marker_q <= (kind == sgbf_pkg::KIND_CLOSE_EOF);
			end
			if (do_pull) begin
				if (emit.done) begin
					drain_q <= 1'b0;
					fill_q <= '0;
					crc_q <= sgbf_pkg::CRC_INIT;
					idx_q <= '0;
					marker_q <= 1'b0;
				end else begin
					idx_q <= idx_q + sgbf_pkg::IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (adv) begin
				res_v_q <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			oval_s1 <= do_pull;
			byte_s1 <= do_pull ? emit.byte_val : 8'h00;
			last_s1 <= do_pull && emit.last;
			ram_s1 <= do_pull && emit.sel_ram;
			priority if (kind == sgbf_pkg::KIND_PULL) begin
				status_s1 <= drain_q ? sgbf_pkg::ST_OK : sgbf_pkg::ST_EMPTY;
			end else if (kind == sgbf_pkg::KIND_BYTE) begin
				status_s1 <= (drain_q || full) ? sgbf_pkg::ST_REFUSED : sgbf_pkg::ST_OK;
			end else begin
				status_s1 <= drain_q ? sgbf_pkg::ST_REFUSED : sgbf_pkg::ST_OK;
			end
		end
		if (adv && v_s1) begin
			oval_q <= oval_s1;
			obyte_q <= ram_s1 ? rdata : byte_s1;
			olast_q <= last_s1;
			status_q <= status_s1;
		end
	end

	assign res_valid = res_v_q;
	assign out_valid = oval_q;
	assign out_byte = obyte_q;
	assign out_last = olast_q;
	assign status = status_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= sgbf_pkg::CNT_W'(sgbf_pkg::STORE_BYTES))
		else $error("fill count beyond store size");

	a_idle_index: assert property (@(posedge clk) disable iff (!arst_n)
		!drain_q |-> (idx_q == '0 && !marker_q))
		else $error("drain index or marker set while not draining");

	a_byte_count: assert property (@(posedge clk) disable iff (!arst_n)
		take_byte |=> fill_q == $past(fill_q) + sgbf_pkg::CNT_W'(1))
		else $error("payload byte not counted");

	a_no_write_drain: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> !take_byte)
		else $error("store written during drain");

	a_ram_pull: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && ram_s1) |-> oval_s1)
		else $error("store read without a pulled byte");

endmodule
